>>> sv/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types, codes and the keyword table of the assembly token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

	localparam int KW_COUNT       = 22;
	localparam int KW_IDX_W       = 5;
	localparam int MAX_WORD_LEN_D = 254;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_W    = 2;

	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 3;
	localparam int VALUE_W = 8;
	localparam int LINE_W  = 16;
	localparam int OUT_W   = 32;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_VALUE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REG   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSTR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

	// class of the word being collected
	localparam logic [1:0] CLS_NONE    = 2'd0;
	localparam logic [1:0] CLS_VALUE   = 2'd1;
	localparam logic [1:0] CLS_REG     = 2'd2;
	localparam logic [1:0] CLS_KEYWORD = 2'd3;

	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;

	// one classified character as it travels through the queue
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              is_end;
		logic              is_sep;
		logic              is_nl;
		logic              is_digit;
		logic              is_pad;    // 0x0B..0x0D, skipped before a number
		logic              is_plus;
		logic              is_minus;
		logic              is_colon;
		logic              is_at;
	} char_cls_t;

	// keyword text, left aligned, zero padded to eight bytes
	function automatic logic [63:0] kw_row(input logic [KW_IDX_W-1:0] k);
		logic [63:0] r;
		case (k)
			5'd0:    r = {"DEPOSIT", 8'h00};
			5'd1:    r = {"LOAD", 32'h0};
			5'd2:    r = {"UNLOAD", 16'h0};
			5'd3:    r = {"PUSH", 32'h0};
			5'd4:    r = {"POP", 40'h0};
			5'd5:    r = {"ADD", 40'h0};
			5'd6:    r = {"SUB", 40'h0};
			5'd7:    r = {"JUMP", 32'h0};
			5'd8:    r = {"EXIT", 32'h0};
			5'd9:    r = {"SKIP", 32'h0};
			5'd10:   r = {"PRT", 40'h0};
			5'd11:   r = {"LABEL", 24'h0};
			5'd12:   r = {"M_MOVE", 16'h0};
			5'd13:   r = {"M_LOAD", 16'h0};
			5'd14:   r = {"M_ADD", 24'h0};
			5'd15:   r = {"M_ADDI", 16'h0};
			5'd16:   r = {"M_SUB", 24'h0};
			5'd17:   r = {"M_SUBI", 16'h0};
			5'd18:   r = {"M_PUSH", 16'h0};
			5'd19:   r = {"M_POP", 24'h0};
			5'd20:   r = {"M_LOOP", 16'h0};
			5'd21:   r = {"M_PRINT", 8'h00};
			default: r = 64'h0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_len(input logic [KW_IDX_W-1:0] k);
		logic [7:0] n;
		case (k)
			5'd0, 5'd21:                              n = 8'd7;
			5'd2, 5'd12, 5'd13, 5'd15, 5'd17, 5'd18,
			5'd20:                                    n = 8'd6;
			5'd11, 5'd14, 5'd16, 5'd19:               n = 8'd5;
			5'd1, 5'd3, 5'd7, 5'd8, 5'd9:             n = 8'd4;
			5'd4, 5'd5, 5'd6, 5'd10:                  n = 8'd3;
			default:                                  n = 8'd0;
		endcase
		return n;
	endfunction

	function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_IDX_W-1:0] k,
			input logic [2:0] p);
		logic [63:0] r;
		logic [2:0]  slot;
		r    = kw_row(k);
		slot = 3'd7 - p;
		return r[8*slot +: 8];
	endfunction

endpackage

>>> sv/assembly_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// assembly_token_lexer_unit
// Lexer for assembly text: one character word in, zero or one token out.
// Input stream s_*: s_tdata[7:0] is a character, byte 0 ends the text.
// Output stream m_*: one token per finished word, an end token or a syntax
// error; m_tlast marks the last token of a text (end, error, or the word
// flushed by byte 0). Separators (space, tab, newline) close words.
// Throughput: one character per cycle while the queue is not full. The core handles
// one queued character per cycle unless a token waits on m_tready; the token
// register is reloaded in the cycle it is taken. An accepted character is written
// into the queue; a token it completes is then loaded into the token register
// behind m_tvalid. A four-entry queue sits between classifier and core, so the
// input keeps flowing while m_tready is low; when it fills, s_tready drops.
// Reset empties the queue, drops any pending token and sets the line count to one.
// ----------------------------------------------------------------------------
module assembly_token_lexer_unit #(
	parameter int MAX_WORD_LEN = atl_pkg::MAX_WORD_LEN_D
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [atl_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_code
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [atl_pkg::OUT_W-1:0] m_tdata,    // [2:0] token_kind, [10:3] token_value,
	                                              // [26:11] line_number, rest zero
	output logic                      m_tlast     // final_flag
);
	import atl_pkg::*;

	char_cls_t in_cls;
	char_cls_t head;
	logic      q_full;
	logic      head_valid;
	logic      pop;
	logic      push;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// front: classify the character
	atl_front u_front (
		.char_code (s_tdata),
		.cls       (in_cls)
	);

	// decoupling queue
	atl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (in_cls),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: word state and token register
	atl_core #(
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

`ifndef SYNTHESIS
	// a token never carries line zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[26:11] != 16'd0))
		else $error("token with line number zero");

	// end and error tokens close a text
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[2:0] == KIND_END) || (m_tdata[2:0] == KIND_ERROR))
		|-> m_tlast && (m_tdata[10:3] == 8'd0))
		else $error("end or error token without last or with value");

	// keyword tokens index inside the table
	a_kw_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == KIND_INSTR) |-> (m_tdata[10:3] < 8'(KW_COUNT)))
		else $error("keyword index out of range");
`endif

endmodule

>>> sv/atl_front.sv
// ----------------------------------------------------------------------------
// atl_front
// Classifies each incoming character for the lexer core.
// ----------------------------------------------------------------------------
module atl_front (
	input  logic [atl_pkg::CHAR_W-1:0] char_code,
	output atl_pkg::char_cls_t         cls
);
	import atl_pkg::*;

	always_comb begin
		cls.ch       = char_code;
		cls.is_end   = (char_code == '0);
		cls.is_nl    = (char_code == CH_NL);
		cls.is_sep   = (char_code == CH_SPACE) || (char_code == CH_TAB) || (char_code == CH_NL);
		cls.is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		cls.is_pad   = (char_code >= CH_VT) && (char_code <= CH_CR);
		cls.is_plus  = (char_code == CH_PLUS);
		cls.is_minus = (char_code == CH_MINUS);
		cls.is_colon = (char_code == CH_COLON);
		cls.is_at    = (char_code == CH_AT);
	end

endmodule

>>> sv/atl_queue.sv
// ----------------------------------------------------------------------------
// atl_queue
// Short queue of classified characters between front and core.
// ----------------------------------------------------------------------------
module atl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  atl_pkg::char_cls_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output atl_pkg::char_cls_t head
);
	import atl_pkg::*;

	char_cls_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full       = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/atl_core.sv
// ----------------------------------------------------------------------------
// atl_core
// Word state machine: keyword mask, number decode, line count, output reg.
// ----------------------------------------------------------------------------
module atl_core #(
	parameter int MAX_WORD_LEN = atl_pkg::MAX_WORD_LEN_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  atl_pkg::char_cls_t         head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [atl_pkg::OUT_W-1:0]  m_tdata,
	output logic                       m_tlast
);
	import atl_pkg::*;

	localparam logic [7:0] POS_LIMIT = 8'(MAX_WORD_LEN);

	logic [1:0]          wclass_q, wclass_n;
	logic [KW_COUNT-1:0] cand_q, cand_n;
	logic [7:0]          pos_q, pos_n;
	logic [7:0]          low_q, low_n;
	logic                ovf_q, ovf_n;
	logic                neg_q, neg_n;
	logic                ended_q, ended_n;
	logic                started_q, started_n;
	logic                err_q, err_n;
	logic [LINE_W-1:0]   line_q, line_n;

	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic                out_last_q;

	// token of the pending word
	logic                kw_hit;
	logic [KW_IDX_W-1:0] kw_idx;
	logic [KIND_W-1:0]   w_kind;
	logic [VALUE_W-1:0]  w_value;

	// per item
	logic                emit;
	logic [KIND_W-1:0]   e_kind;
	logic [VALUE_W-1:0]  e_value;
	logic                e_last;
	logic [1:0]          cls_eff;
	logic [11:0]         acc;

	assign pop      = head_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand_q[k] && (kw_len(KW_IDX_W'(k)) == pos_q)) begin
				kw_hit = 1'b1;
				kw_idx = KW_IDX_W'(k);
			end
		end
		if ((wclass_q == CLS_VALUE) || (wclass_q == CLS_REG)) begin
			w_kind = (wclass_q == CLS_VALUE) ? KIND_VALUE : KIND_REG;
			if (neg_q) begin
				w_value = 8'(8'd0 - low_q);
			end else begin
				w_value = ovf_q ? 8'd0 : low_q;
			end
		end else if (kw_hit) begin
			w_kind  = KIND_INSTR;
			w_value = VALUE_W'(kw_idx);
		end else begin
			w_kind  = KIND_ERROR;
			w_value = '0;
		end
	end

	always_comb begin
		wclass_n  = wclass_q;
		cand_n    = cand_q;
		pos_n     = pos_q;
		low_n     = low_q;
		ovf_n     = ovf_q;
		neg_n     = neg_q;
		ended_n   = ended_q;
		started_n = started_q;
		err_n     = err_q;
		line_n    = line_q;
		emit      = 1'b0;
		e_kind    = w_kind;
		e_value   = w_value;
		e_last    = (w_kind == KIND_ERROR);
		cls_eff   = wclass_q;
		acc       = {1'b0, low_q, 3'b0} + {3'b0, low_q, 1'b0} + {8'b0, head.ch[3:0]};

		if (err_q) begin
			if (head.is_end) begin
				err_n     = 1'b0;
				wclass_n  = CLS_NONE;
				cand_n    = '1;
				pos_n     = '0;
				low_n     = '0;
				ovf_n     = 1'b0;
				neg_n     = 1'b0;
				ended_n   = 1'b0;
				started_n = 1'b0;
				line_n    = LINE_W'(1);
			end
		end else if (head.is_end) begin
			emit = 1'b1;
			if (wclass_q == CLS_NONE) begin
				e_kind  = KIND_END;
				e_value = '0;
			end
			e_last    = 1'b1;
			wclass_n  = CLS_NONE;
			cand_n    = '1;
			pos_n     = '0;
			low_n     = '0;
			ovf_n     = 1'b0;
			neg_n     = 1'b0;
			ended_n   = 1'b0;
			started_n = 1'b0;
			line_n    = LINE_W'(1);
		end else if (head.is_sep) begin
			if (wclass_q != CLS_NONE) begin
				emit      = 1'b1;
				err_n     = (w_kind == KIND_ERROR);
				wclass_n  = CLS_NONE;
				cand_n    = '1;
				pos_n     = '0;
				low_n     = '0;
				ovf_n     = 1'b0;
				neg_n     = 1'b0;
				ended_n   = 1'b0;
				started_n = 1'b0;
			end
			if (head.is_nl && (line_q != LINE_MAX)) begin
				line_n = line_q + 1'b1;
			end
		end else if (pos_q < POS_LIMIT) begin
			if (pos_q == '0) begin
				if (head.is_colon) begin
					cls_eff = CLS_VALUE;
				end else if (head.is_at) begin
					cls_eff = CLS_REG;
				end else begin
					cls_eff = CLS_KEYWORD;
				end
			end
			wclass_n = cls_eff;
			if (cls_eff == CLS_KEYWORD) begin
				for (int k = 0; k < KW_COUNT; k++) begin
					cand_n[k] = cand_q[k] && (pos_q < kw_len(KW_IDX_W'(k)))
						&& (kw_char(KW_IDX_W'(k), pos_q[2:0]) == head.ch);
				end
			end else if ((pos_q != '0) && !ended_q) begin
				if (!started_q && head.is_pad) begin
					// leading pad bytes are skipped
				end else if (!started_q && (head.is_plus || head.is_minus)) begin
					started_n = 1'b1;
					neg_n     = head.is_minus;
				end else begin
					started_n = 1'b1;
					if (head.is_digit) begin
						low_n = acc[7:0];
						if (acc > 12'd255) begin
							ovf_n = 1'b1;
						end
					end else begin
						ended_n = 1'b1;
					end
				end
			end
			pos_n = pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wclass_q    <= CLS_NONE;
			cand_q      <= '1;
			pos_q       <= '0;
			low_q       <= '0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
			ended_q     <= 1'b0;
			started_q   <= 1'b0;
			err_q       <= 1'b0;
			line_q      <= LINE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				wclass_q  <= wclass_n;
				cand_q    <= cand_n;
				pos_q     <= pos_n;
				low_q     <= low_n;
				ovf_q     <= ovf_n;
				neg_q     <= neg_n;
				ended_q   <= ended_n;
				started_q <= started_n;
				err_q     <= err_n;
				line_q    <= line_n;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_data_q <= {5'b0, line_q, e_value, e_kind};
			out_last_q <= e_last;
		end
	end

endmodule
